// File: rtl/core/cpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants for the closest-point-on-triangle pipeline: default
// coordinate width, multiplier chunk sizes and the region codes.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int VMUL_CHUNK      = 17;
    localparam int NMUL_CHUNK      = 8;
    localparam int REGION_WIDTH    = 3;

    localparam logic [REGION_WIDTH-1:0] REG_VTX_A    = 3'd0;
    localparam logic [REGION_WIDTH-1:0] REG_VTX_B    = 3'd1;
    localparam logic [REGION_WIDTH-1:0] REG_EDGE_AB  = 3'd2;
    localparam logic [REGION_WIDTH-1:0] REG_VTX_C    = 3'd3;
    localparam logic [REGION_WIDTH-1:0] REG_EDGE_AC  = 3'd4;
    localparam logic [REGION_WIDTH-1:0] REG_EDGE_BC  = 3'd5;
    localparam logic [REGION_WIDTH-1:0] REG_INTERIOR = 3'd6;

endpackage
`default_nettype wire

// File: rtl/core/cpt_query_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_query_if
// Query channel: one word carries the query point and the three vertices.
// ----------------------------------------------------------------------------
interface cpt_query_if #(parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;

    modport source (
        output valid, point_x, point_y, point_z,
        output vertex_a_x, vertex_a_y, vertex_a_z,
        output vertex_b_x, vertex_b_y, vertex_b_z,
        output vertex_c_x, vertex_c_y, vertex_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z,
        input  vertex_a_x, vertex_a_y, vertex_a_z,
        input  vertex_b_x, vertex_b_y, vertex_b_z,
        input  vertex_c_x, vertex_c_y, vertex_c_z,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/cpt_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_result_if
// Result channel: one word carries the nearest point and its region code.
// ----------------------------------------------------------------------------
interface cpt_result_if #(parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     nearest_x;
    logic signed [COORD_WIDTH-1:0]     nearest_y;
    logic signed [COORD_WIDTH-1:0]     nearest_z;
    logic [cpt_pkg::REGION_WIDTH-1:0]  region;

    modport source (output valid, nearest_x, nearest_y, nearest_z, region, input ready);
    modport sink   (input  valid, nearest_x, nearest_y, nearest_z, region, output ready);
endinterface
`default_nettype wire

// File: rtl/core/cpt_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_mul
// Pipelined signed multiplier: each stage adds the product of a with one
// CW-bit digit of b, the top digit taken as signed.
// ----------------------------------------------------------------------------
module cpt_mul #(
    parameter int AW = 40,
    parameter int BW = 40,
    parameter int CW = 16
) (
    input  logic                       clk,
    input  logic [(BW+CW-1)/CW-1:0]    en,
    input  logic signed [AW-1:0]       a,
    input  logic signed [BW-1:0]       b,
    output logic signed [AW+BW-1:0]    p
);

    localparam int NS  = (BW + CW - 1) / CW;
    localparam int XW  = NS * CW;
    localparam int PWD = AW + BW;

    logic signed [AW-1:0]  a_reg   [NS-1];
    logic signed [XW-1:0]  b_reg   [NS-1];
    logic signed [PWD-1:0] acc_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [AW-1:0]  a_in;
        logic signed [XW-1:0]  b_in;
        logic signed [PWD-1:0] acc_in;
        logic signed [CW:0]    dig;
        logic signed [AW+CW:0] prod;

        if (k == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = XW'(b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        if (k == NS - 1) begin : g_top
            assign dig = (CW+1)'($signed(b_in[k*CW +: CW]));
        end else begin : g_low
            assign dig = $signed({1'b0, b_in[k*CW +: CW]});
        end

        assign prod = a_in * dig;

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                acc_reg[k] <= acc_in + (PWD'(prod) <<< (k * CW));
            end
        end

        if (k < NS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    a_reg[k] <= a_in;
                    b_reg[k] <= b_in;
                end
            end
        end
    end

    assign p = acc_reg[NS-1];

endmodule
`default_nettype wire

// File: rtl/core/closest_point_on_triangle_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_point_on_triangle_unit
// Nearest point of a triangle to a query point, with its Voronoi region.
//
// query carries one word per query: point and vertices a, b, c, signed
// fixed point (Q16.16 at the default width). result returns one word per
// query, in order: the nearest point, saturated to the coordinate range,
// and the region code (vertex a, vertex b, edge ab, vertex c, edge ac,
// edge bc, interior). A degenerate edge or face returns its start point.
// A new query is taken every cycle unless the pipeline is full and stalled.
// The chunked multipliers for the region determinants and the numerators,
// and one quotient bit per stage in the restoring divider, set the depth.
// Valid bits travel with every stage; a stage holds while the one after it
// is full and stalled, so bubbles close up and a stalled result keeps its
// word while earlier stages still accept. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_unit #(
    parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cpt_query_if.sink     query,
    cpt_result_if.source  result
);
    import cpt_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * W + 3;
    localparam int VW   = 2 * PW + 1;
    localparam int DENW = VW + 2;
    localparam int NW   = DW + VW + 1;
    localparam int QB   = W + 1;
    localparam int RW   = W + VW + 4;
    localparam int SW   = W + 4;
    localparam int NSV  = (PW + VMUL_CHUNK - 1) / VMUL_CHUNK;
    localparam int NSN  = (DW + NMUL_CHUNK - 1) / NMUL_CHUNK;

    localparam int S_DIFF = 0;
    localparam int S_PROD = 1;
    localparam int S_DOT  = 2;
    localparam int S_VM0  = 3;
    localparam int S_SEL  = S_VM0 + NSV;
    localparam int S_NM0  = S_SEL + 1;
    localparam int S_SUM  = S_NM0 + NSN;
    localparam int S_ND   = S_SUM + 1;
    localparam int S_DV0  = S_ND + 1;
    localparam int S_OUT  = S_DV0 + QB + 1;
    localparam int L      = S_OUT + 1;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [2:0][W-1:0]  a, b, c;
        logic [2:0][DW-1:0] ab, ac, ap, bp, cp, bc;
    } df_t;

    typedef struct packed {
        logic [5:0][2:0][2*DW-1:0] pr;
        logic [2:0][W-1:0]         a, b, c;
        logic [2:0][DW-1:0]        ab, ac, bc;
    } pr_t;

    typedef struct packed {
        logic [5:0][PW-1:0] d;
        logic [2:0][W-1:0]  a, b, c;
        logic [2:0][DW-1:0] ab, ac, bc;
    } dt_t;

    typedef struct packed {
        logic [VW-1:0]          num1, num2;
        logic [2:0][DW-1:0]     dir1, dir2;
        logic [DENW-1:0]        den;
        logic [2:0][W-1:0]      start;
        logic                   use_start;
        logic [REGION_WIDTH-1:0] region;
    } sel_t;

    typedef struct packed {
        logic [DENW-1:0]         den;
        logic [2:0][W-1:0]       start;
        logic                    use_start;
        logic [REGION_WIDTH-1:0] region;
    } ns_t;

    typedef struct packed {
        logic [2:0][NW-1:0]      num;
        logic [DENW-1:0]         den;
        logic [2:0][W-1:0]       start;
        logic                    use_start;
        logic [REGION_WIDTH-1:0] region;
    } sm_t;

    typedef struct packed {
        logic [2:0][RW-1:0]      n;
        logic [RW-1:0]           dd;
        logic [2:0]              neg;
        logic [2:0][W-1:0]       start;
        logic                    use_start;
        logic [REGION_WIDTH-1:0] region;
    } nd_t;

    typedef struct packed {
        logic [2:0][RW-1:0]      rem;
        logic [2:0][QB-1:0]      q;
        logic [2:0]              ovf;
        logic [2:0]              neg;
        logic [RW-1:0]           dd;
        logic [2:0][W-1:0]       start;
        logic                    use_start;
        logic [REGION_WIDTH-1:0] region;
    } dv_t;

    typedef struct packed {
        logic [2:0][W-1:0]       nearest;
        logic [REGION_WIDTH-1:0] region;
    } out_t;

    // stage enables and valid bits
    logic [L:0]   en;
    logic [L-1:0] valid_reg;
    logic [L-1:0] valid_in;

    assign en[L] = result.ready;
    for (genvar s = 0; s < L; s++) begin : g_en
        assign en[s] = ~valid_reg[s] | en[s+1];
    end

    assign valid_in = {valid_reg[L-2:0], query.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < L; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    assign query.ready  = en[S_DIFF];
    assign result.valid = valid_reg[L-1];

    // differences
    logic [2:0][W-1:0] qp, qa, qb, qc;
    assign qp = {query.point_z, query.point_y, query.point_x};
    assign qa = {query.vertex_a_z, query.vertex_a_y, query.vertex_a_x};
    assign qb = {query.vertex_b_z, query.vertex_b_y, query.vertex_b_x};
    assign qc = {query.vertex_c_z, query.vertex_c_y, query.vertex_c_x};

    df_t df_next, df_reg;

    always_comb
    begin
        df_next   = '0;
        df_next.a = qa;
        df_next.b = qb;
        df_next.c = qc;
        for (int k = 0; k < 3; k++)
        begin
            df_next.ab[k] = DW'($signed(qb[k])) - DW'($signed(qa[k]));
            df_next.ac[k] = DW'($signed(qc[k])) - DW'($signed(qa[k]));
            df_next.ap[k] = DW'($signed(qp[k])) - DW'($signed(qa[k]));
            df_next.bp[k] = DW'($signed(qp[k])) - DW'($signed(qb[k]));
            df_next.cp[k] = DW'($signed(qp[k])) - DW'($signed(qc[k]));
            df_next.bc[k] = DW'($signed(qc[k])) - DW'($signed(qb[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DIFF])
        begin
            df_reg <= df_next;
        end
    end

    // component products
    pr_t pr_next, pr_reg;
    logic signed [2*DW-1:0] prod_v [6][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_v[0][k] = $signed(df_reg.ab[k]) * $signed(df_reg.ap[k]);
            prod_v[1][k] = $signed(df_reg.ac[k]) * $signed(df_reg.ap[k]);
            prod_v[2][k] = $signed(df_reg.ab[k]) * $signed(df_reg.bp[k]);
            prod_v[3][k] = $signed(df_reg.ac[k]) * $signed(df_reg.bp[k]);
            prod_v[4][k] = $signed(df_reg.ab[k]) * $signed(df_reg.cp[k]);
            prod_v[5][k] = $signed(df_reg.ac[k]) * $signed(df_reg.cp[k]);
        end
        pr_next    = '0;
        pr_next.a  = df_reg.a;
        pr_next.b  = df_reg.b;
        pr_next.c  = df_reg.c;
        pr_next.ab = df_reg.ab;
        pr_next.ac = df_reg.ac;
        pr_next.bc = df_reg.bc;
        for (int i = 0; i < 6; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pr_next.pr[i][k] = prod_v[i][k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
        begin
            pr_reg <= pr_next;
        end
    end

    // dot products d1..d6
    dt_t dt_next, dt_reg;

    always_comb
    begin
        dt_next    = '0;
        dt_next.a  = pr_reg.a;
        dt_next.b  = pr_reg.b;
        dt_next.c  = pr_reg.c;
        dt_next.ab = pr_reg.ab;
        dt_next.ac = pr_reg.ac;
        dt_next.bc = pr_reg.bc;
        for (int i = 0; i < 6; i++)
        begin
            dt_next.d[i] = PW'($signed(pr_reg.pr[i][0])) + PW'($signed(pr_reg.pr[i][1]))
                         + PW'($signed(pr_reg.pr[i][2]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DOT])
        begin
            dt_reg <= dt_next;
        end
    end

    // region determinant products
    logic signed [2*PW-1:0] vm [6];
    dt_t vs_reg [NSV];

    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm0 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[0])), .b($signed(dt_reg.d[3])), .p(vm[0]));
    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm1 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[2])), .b($signed(dt_reg.d[1])), .p(vm[1]));
    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm2 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[4])), .b($signed(dt_reg.d[1])), .p(vm[2]));
    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm3 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[0])), .b($signed(dt_reg.d[5])), .p(vm[3]));
    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm4 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[2])), .b($signed(dt_reg.d[5])), .p(vm[4]));
    cpt_mul #(.AW(PW), .BW(PW), .CW(VMUL_CHUNK)) u_vm5 (.clk(clk), .en(en[S_VM0 +: NSV]),
        .a($signed(dt_reg.d[4])), .b($signed(dt_reg.d[3])), .p(vm[5]));

    always_ff @(posedge clk)
    begin
        if (en[S_VM0])
        begin
            vs_reg[0] <= dt_reg;
        end
        for (int k = 1; k < NSV; k++)
        begin
            if (en[S_VM0+k])
            begin
                vs_reg[k] <= vs_reg[k-1];
            end
        end
    end

    // region decision and operand select
    dt_t vs;
    logic signed [PW-1:0]   d1, d2, d3, d4, d5, d6;
    logic signed [VW-1:0]   va, vb, vc;
    logic signed [PW:0]     e1, e2, den_ab, den_ac;
    logic signed [PW+1:0]   den_bc;
    logic signed [DENW-1:0] den_in;
    sel_t sel_next, sel_reg;

    assign vs     = vs_reg[NSV-1];
    assign d1     = $signed(vs.d[0]);
    assign d2     = $signed(vs.d[1]);
    assign d3     = $signed(vs.d[2]);
    assign d4     = $signed(vs.d[3]);
    assign d5     = $signed(vs.d[4]);
    assign d6     = $signed(vs.d[5]);
    assign vc     = VW'(vm[0]) - VW'(vm[1]);
    assign vb     = VW'(vm[2]) - VW'(vm[3]);
    assign va     = VW'(vm[4]) - VW'(vm[5]);
    assign e1     = (PW+1)'(d4) - (PW+1)'(d3);
    assign e2     = (PW+1)'(d5) - (PW+1)'(d6);
    assign den_ab = (PW+1)'(d1) - (PW+1)'(d3);
    assign den_ac = (PW+1)'(d2) - (PW+1)'(d6);
    assign den_bc = (PW+2)'(e1) + (PW+2)'(e2);
    assign den_in = DENW'(va) + DENW'(vb) + DENW'(vc);

    always_comb
    begin
        sel_next       = '0;
        sel_next.start = vs.a;
        if (d1 <= 0 && d2 <= 0)
        begin
            sel_next.use_start = 1'b1;
            sel_next.region    = REG_VTX_A;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            sel_next.start     = vs.b;
            sel_next.use_start = 1'b1;
            sel_next.region    = REG_VTX_B;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            sel_next.num1   = VW'(d1);
            sel_next.dir1   = vs.ab;
            sel_next.den    = DENW'(den_ab);
            sel_next.region = REG_EDGE_AB;
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            sel_next.start     = vs.c;
            sel_next.use_start = 1'b1;
            sel_next.region    = REG_VTX_C;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            sel_next.num1   = VW'(d2);
            sel_next.dir1   = vs.ac;
            sel_next.den    = DENW'(den_ac);
            sel_next.region = REG_EDGE_AC;
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            sel_next.start  = vs.b;
            sel_next.num1   = VW'(e1);
            sel_next.dir1   = vs.bc;
            sel_next.den    = DENW'(den_bc);
            sel_next.region = REG_EDGE_BC;
        end
        else
        begin
            sel_next.num1   = vb;
            sel_next.dir1   = vs.ab;
            sel_next.num2   = vc;
            sel_next.dir2   = vs.ac;
            sel_next.den    = den_in;
            sel_next.region = REG_INTERIOR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SEL])
        begin
            sel_reg <= sel_next;
        end
    end

    // numerators: dir * num per component
    logic signed [VW+DW-1:0] nm1 [3];
    logic signed [VW+DW-1:0] nm2 [3];
    ns_t ns_next;
    ns_t ns_reg [NSN];

    for (genvar k = 0; k < 3; k++) begin : g_num
        cpt_mul #(.AW(VW), .BW(DW), .CW(NMUL_CHUNK)) u_nm1 (.clk(clk),
            .en(en[S_NM0 +: NSN]), .a($signed(sel_reg.num1)),
            .b($signed(sel_reg.dir1[k])), .p(nm1[k]));
        cpt_mul #(.AW(VW), .BW(DW), .CW(NMUL_CHUNK)) u_nm2 (.clk(clk),
            .en(en[S_NM0 +: NSN]), .a($signed(sel_reg.num2)),
            .b($signed(sel_reg.dir2[k])), .p(nm2[k]));
    end

    assign ns_next = '{den: sel_reg.den, start: sel_reg.start,
                       use_start: sel_reg.use_start, region: sel_reg.region};

    always_ff @(posedge clk)
    begin
        if (en[S_NM0])
        begin
            ns_reg[0] <= ns_next;
        end
        for (int k = 1; k < NSN; k++)
        begin
            if (en[S_NM0+k])
            begin
                ns_reg[k] <= ns_reg[k-1];
            end
        end
    end

    // numerator sum
    ns_t ns;
    sm_t sm_next, sm_reg;
    assign ns = ns_reg[NSN-1];

    always_comb
    begin
        sm_next           = '0;
        sm_next.den       = ns.den;
        sm_next.start     = ns.start;
        sm_next.use_start = ns.use_start | (ns.den == '0);
        sm_next.region    = ns.region;
        for (int k = 0; k < 3; k++)
        begin
            sm_next.num[k] = NW'(nm1[k]) + NW'(nm2[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            sm_reg <= sm_next;
        end
    end

    // rounding operands: (2|num| + |den|) / (2|den|)
    nd_t nd_next, nd_reg;
    logic signed [RW-1:0] num_x [3];
    logic signed [RW-1:0] num_m [3];
    logic signed [RW-1:0] den_x, den_m;

    always_comb
    begin
        den_x = RW'($signed(sm_reg.den));
        den_m = den_x[RW-1] ? -den_x : den_x;
        nd_next           = '0;
        nd_next.dd        = RW'(den_m <<< 1);
        nd_next.start     = sm_reg.start;
        nd_next.use_start = sm_reg.use_start;
        nd_next.region    = sm_reg.region;
        for (int k = 0; k < 3; k++)
        begin
            num_x[k]       = RW'($signed(sm_reg.num[k]));
            num_m[k]       = num_x[k][RW-1] ? -num_x[k] : num_x[k];
            nd_next.n[k]   = RW'((num_m[k] <<< 1) + den_m);
            nd_next.neg[k] = sm_reg.num[k][NW-1] ^ sm_reg.den[DENW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_ND])
        begin
            nd_reg <= nd_next;
        end
    end

    // restoring divider, one quotient bit per stage
    dv_t dv_next0;
    dv_t dv_reg [QB+1];

    always_comb
    begin
        dv_next0           = '0;
        dv_next0.rem       = nd_reg.n;
        dv_next0.neg       = nd_reg.neg;
        dv_next0.dd        = nd_reg.dd;
        dv_next0.start     = nd_reg.start;
        dv_next0.use_start = nd_reg.use_start;
        dv_next0.region    = nd_reg.region;
        for (int k = 0; k < 3; k++)
        begin
            dv_next0.ovf[k] = nd_reg.n[k] >= (nd_reg.dd << QB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DV0])
        begin
            dv_reg[0] <= dv_next0;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        dv_t           nxt;
        logic [RW-1:0] trial;

        always_comb
        begin
            nxt   = dv_reg[j-1];
            trial = dv_reg[j-1].dd << (QB - j);
            for (int k = 0; k < 3; k++)
            begin
                if (nxt.rem[k] >= trial)
                begin
                    nxt.rem[k]        = nxt.rem[k] - trial;
                    nxt.q[k][QB-j]    = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[S_DV0+j])
            begin
                dv_reg[j] <= nxt;
            end
        end
    end

    // add to start point and saturate
    dv_t dv;
    out_t out_next, out_reg;
    logic [QB:0]          qm  [3];
    logic signed [SW-1:0] sv  [3];
    logic signed [SW-1:0] tot [3];
    assign dv = dv_reg[QB];

    always_comb
    begin
        out_next        = '0;
        out_next.region = dv.region;
        for (int k = 0; k < 3; k++)
        begin
            qm[k]  = dv.ovf[k] ? {1'b1, {QB{1'b0}}} : {1'b0, dv.q[k]};
            sv[k]  = SW'($signed({1'b0, qm[k]}));
            if (dv.neg[k])
            begin
                sv[k] = -sv[k];
            end
            tot[k] = SW'($signed(dv.start[k])) + sv[k];
            if (dv.use_start)
            begin
                out_next.nearest[k] = dv.start[k];
            end
            else if (tot[k] > SAT_HI)
            begin
                out_next.nearest[k] = SAT_HI[W-1:0];
            end
            else if (tot[k] < SAT_LO)
            begin
                out_next.nearest[k] = SAT_LO[W-1:0];
            end
            else
            begin
                out_next.nearest[k] = tot[k][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign result.nearest_x = $signed(out_reg.nearest[0]);
    assign result.nearest_y = $signed(out_reg.nearest[1]);
    assign result.nearest_z = $signed(out_reg.nearest[2]);
    assign result.region    = out_reg.region;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for closest_point_on_triangle_unit: directed region,
// degenerate and extreme queries, then randomized triangles, under bursty
// query traffic and result stalls. Every result word is checked against an
// exact wide-integer computation of the nearest point and region.
// ----------------------------------------------------------------------------
module tb;

    localparam int CW = cpt_pkg::COORD_WIDTH_DEF;
    localparam int ONE = 65536;
    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [255:0] wide_t;
    typedef wide_t vec_t [3];

    typedef struct {
        coord_t pt [3];
        coord_t va [3];
        coord_t vb [3];
        coord_t vc [3];
    } query_t;

    typedef struct {
        coord_t                            near [3];
        logic [cpt_pkg::REGION_WIDTH-1:0]  region;
    } nearest_t;

    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

    logic clk;
    logic rst_n;

    cpt_query_if  #(.COORD_WIDTH(CW)) query ();
    cpt_result_if #(.COORD_WIDTH(CW)) result ();

    closest_point_on_triangle_unit #(.COORD_WIDTH(CW)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result)
    );

    nearest_t nearest_q [$];
    int       mismatches = 0;
    int       burst_left = 0;
    int       cycles = 0;
    logic     hold_req = 0;
    logic     hold_active = 0;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // exact nearest-point computation

    function automatic wide_t div_round(wide_t n, wide_t d);
        wide_t mn;
        wide_t md;
        wide_t q;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        q = (2 * mn + md) / (2 * md);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic coord_t clamp(wide_t v);
        if (v > wide_t'(CMAX))
            return CMAX;
        if (v < wide_t'(CMIN))
            return CMIN;
        return v[CW-1:0];
    endfunction

    function automatic wide_t dot3(vec_t x, vec_t y);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic nearest_t on_edge(vec_t s, vec_t dir, wide_t num, wide_t den,
                                         logic [cpt_pkg::REGION_WIDTH-1:0] reg_code);
        nearest_t r;
        wide_t    v;
        for (int k = 0; k < 3; k++)
        begin
            v = s[k];
            if (den != 0)
                v = v + div_round(dir[k] * num, den);
            r.near[k] = clamp(v);
        end
        r.region = reg_code;
        return r;
    endfunction

    function automatic nearest_t at_vertex(vec_t v, logic [cpt_pkg::REGION_WIDTH-1:0] reg_code);
        nearest_t r;
        for (int k = 0; k < 3; k++)
            r.near[k] = clamp(v[k]);
        r.region = reg_code;
        return r;
    endfunction

    function automatic nearest_t predict_nearest(query_t q);
        vec_t     p, a, b, c, ab, ac, ap, bp, cp, bc;
        wide_t    d1, d2, d3, d4, d5, d6, wa, wb, wc, e1, e2, den, v;
        nearest_t r;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = q.pt[k];
            a[k] = q.va[k];
            b[k] = q.vb[k];
            c[k] = q.vc[k];
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            bc[k] = c[k] - b[k];
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        if (d1 <= 0 && d2 <= 0)
            return at_vertex(a, cpt_pkg::REG_VTX_A);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        if (d3 >= 0 && d4 <= d3)
            return at_vertex(b, cpt_pkg::REG_VTX_B);
        wc = d1 * d4 - d3 * d2;
        if (wc <= 0 && d1 >= 0 && d3 <= 0)
            return on_edge(a, ab, d1, d1 - d3, cpt_pkg::REG_EDGE_AB);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        if (d6 >= 0 && d5 <= d6)
            return at_vertex(c, cpt_pkg::REG_VTX_C);
        wb = d5 * d2 - d1 * d6;
        if (wb <= 0 && d2 >= 0 && d6 <= 0)
            return on_edge(a, ac, d2, d2 - d6, cpt_pkg::REG_EDGE_AC);
        wa = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        if (wa <= 0 && e1 >= 0 && e2 >= 0)
            return on_edge(b, bc, e1, e1 + e2, cpt_pkg::REG_EDGE_BC);
        den = wa + wb + wc;
        for (int k = 0; k < 3; k++)
        begin
            v = a[k];
            if (den != 0)
                v = v + div_round(ab[k] * wb + ac[k] * wc, den);
            r.near[k] = clamp(v);
        end
        r.region = cpt_pkg::REG_INTERIOR;
        return r;
    endfunction

    // query side

    task automatic send_query(query_t q);
        if (burst_left == 0)
        begin
            query.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        query.valid      <= 1'b1;
        query.point_x    <= q.pt[0];
        query.point_y    <= q.pt[1];
        query.point_z    <= q.pt[2];
        query.vertex_a_x <= q.va[0];
        query.vertex_a_y <= q.va[1];
        query.vertex_a_z <= q.va[2];
        query.vertex_b_x <= q.vb[0];
        query.vertex_b_y <= q.vb[1];
        query.vertex_b_z <= q.vb[2];
        query.vertex_c_x <= q.vc[0];
        query.vertex_c_y <= q.vc[1];
        query.vertex_c_z <= q.vc[2];
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        nearest_q = {nearest_q, predict_nearest(q)};
        burst_left--;
    endtask

    function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
        query_t q;
        q.pt = '{px, py, pz};
        q.va = '{ax, ay, az};
        q.vb = '{bx, by, bz};
        q.vc = '{cx, cy, cz};
        return q;
    endfunction

    function automatic coord_t rand_coord(int unsigned span);
        return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
    endfunction

    function automatic query_t rand_query();
        query_t      q;
        int unsigned kind;
        int unsigned span;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 32'd200 : (32'd1 << $urandom_range(10, 22));
        for (int k = 0; k < 3; k++)
        begin
            if (kind < 2)
            begin
                q.pt[k] = $urandom;
                q.va[k] = $urandom;
                q.vb[k] = $urandom;
                q.vc[k] = $urandom;
            end
            else
            begin
                q.va[k] = rand_coord(span);
                q.vb[k] = rand_coord(span);
                q.vc[k] = rand_coord(span);
                q.pt[k] = rand_coord(span + span / 2);
            end
        end
        case (kind)
            2: q.vb = q.va;
            3:
            begin
                for (int k = 0; k < 3; k++)
                    q.vc[k] = q.va[k] + 2 * (q.vb[k] - q.va[k]);
            end
            4: q.pt = q.vc;
            default: ;
        endcase
        return q;
    endfunction

    // result side

    always @(posedge clk)
    begin
        int mode;
        int mode_left;
        if (mode_left <= 0)
        begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_active)
            result.ready <= 1'b0;
        else if (mode == 0)
            result.ready <= 1'b1;
        else if (mode == 1)
            result.ready <= ($urandom_range(0, 99) < 65);
        else
            result.ready <= (cycles % 7 < 4);
    end

    initial
    begin
        forever
        begin
            wait (hold_req);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (400) @(posedge clk);
            hold_active <= 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        nearest_t exp_w;
        if (rst_n && result.valid && result.ready)
        begin
            if (nearest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word region %0d", result.region);
            end
            else
            begin
                exp_w = nearest_q.pop_front();
                if (result.nearest_x !== exp_w.near[0] || result.nearest_y !== exp_w.near[1]
                    || result.nearest_z !== exp_w.near[2] || result.region !== exp_w.region)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp (%0d %0d %0d) r%0d got (%0d %0d %0d) r%0d",
                                 exp_w.near[0], exp_w.near[1], exp_w.near[2], exp_w.region,
                                 result.nearest_x, result.nearest_y, result.nearest_z,
                                 result.region);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // tests

    task automatic test_regions();
        // unit triangle in the z = 0 plane, one query per region
        send_query(make_query(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(2 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(ONE / 2, -ONE, 7, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(0, 2 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(-ONE, ONE / 2, -3, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        send_query(make_query(ONE / 4, ONE / 4, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        // tiny triangle, quotients land on thirds and halves
        send_query(make_query(1, 1, 5, 0, 0, 0, 3, 0, 0, 0, 3, 0));
        send_query(make_query(1, -4, 0, 0, 0, 0, 2, 0, 0, 0, 2, 0));
        send_query(make_query(-1, -1, 2, 0, 0, 0, -3, 0, 0, 0, -3, 0));
        send_query(make_query(2, 2, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0));
    endtask

    task automatic test_degenerate();
        send_query(make_query(5, 9, -2, 3, 3, 3, 3, 3, 3, 3, 3, 3));
        send_query(make_query(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
        send_query(make_query(ONE, -ONE, 4, 0, 0, 0, 0, 0, 0, ONE, ONE, 0));
        send_query(make_query(3, 5, 1, 0, 0, 0, ONE, 0, 0, ONE, 0, 0));
        send_query(make_query(-7, 2, 0, 0, 0, 0, 2, 2, 2, -2, -2, -2));
    endtask

    task automatic test_extremes();
        send_query(make_query(CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                              CMIN, CMAX, 0));
        send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, 0,
                              CMIN, CMAX, CMIN));
        send_query(make_query(0, 0, 0, CMIN, 0, 0, CMAX, 0, 0, 0, CMAX, CMIN));
        send_query(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX,
                              CMAX, CMIN, CMIN));
        send_query(make_query(-1, -1, -1, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                              CMAX, CMAX, CMIN));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_query(rand_query());
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 120; i++)
            send_query(rand_query());
    endtask

    initial
    begin
        rst_n = 1'b0;
        query.valid = 1'b0;
        query.point_x = '0;
        query.point_y = '0;
        query.point_z = '0;
        query.vertex_a_x = '0;
        query.vertex_a_y = '0;
        query.vertex_a_z = '0;
        query.vertex_b_x = '0;
        query.vertex_b_y = '0;
        query.vertex_b_z = '0;
        query.vertex_c_x = '0;
        query.vertex_c_y = '0;
        query.vertex_c_z = '0;
        result.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_regions();
        test_degenerate();
        test_extremes();
        test_random(500);
        test_backpressure();
        test_random(510);
        query.valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
